// File: hw/rtl/psds_pkg.sv
// ============================================================================
// psds_pkg: shared types for the point slot table
// Transaction structs, request and status codes, and the per-cell control word
// that the top level broadcasts to the row of slot cells.
// ============================================================================
package psds_pkg;

    typedef enum logic [3:0] {
        OP_ADD_TOP = 4'd0,
        OP_REM_TOP = 4'd1,
        OP_ADD_BOT = 4'd2,
        OP_REM_BOT = 4'd3,
        OP_COUNT   = 4'd4,
        OP_ROTATE  = 4'd5,
        OP_CLEAR   = 4'd6,
        OP_SORT    = 4'd7,
        OP_READ    = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIST,
        ST_SORT
    } state_t;

    typedef enum logic [3:0] {
        CELL_HOLD,
        CELL_ADD_TOP,
        CELL_REM_TOP,
        CELL_ADD_BOT,
        CELL_REM_BOT,
        CELL_ROTATE,
        CELL_CLEAR,
        CELL_DIST,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     odd_phase;
    } cell_ctl_t;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [3:0]         slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         point_count;
        logic               slot_present;
        logic signed [15:0] slot_x;
        logic signed [15:0] slot_y;
        logic signed [15:0] slot_z;
    } rsp_t;

endpackage

// File: hw/rtl/point_slot_table_with_distance_sort.sv
// ============================================================================
// point_slot_table_with_distance_sort: slot table of 3D points with sort
// A row of slot cells keeps the points; a small controller decodes requests,
// broadcasts a cell operation and returns one response per request.
// ============================================================================
// Response: add, remove, count, rotate, clear and read give a registered response,
// valid in the cycle after the accepted request; sort first computes squared
// distances, then runs SLOTS odd-even exchange phases in the row before its response.
// Requests: one request per cycle for simple requests while the response is not
// stalled; a sort takes no new request until it has loaded its response.
// Reset: all slots empty, count zero, no response pending.
// ============================================================================
module point_slot_table_with_distance_sort #(
    parameter int SLOTS      = 16,
    parameter int COORD_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  psds_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output psds_pkg::rsp_t  rsp
);

    localparam int CB    = COORD_BITS;
    localparam int PW    = 3 * CB;
    localparam int DW    = 2 * CB;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IW    = $clog2(SLOTS);
    localparam int PH_W  = $clog2(SLOTS);

    // Cell row wiring.
    logic          cell_v [SLOTS];
    logic [PW-1:0] cell_pt [SLOTS];
    logic [DW-1:0] cell_d [SLOTS];
    logic          free_below [SLOTS];
    logic          valid_below [SLOTS];
    logic          valid_above [SLOTS];
    logic          hole [SLOTS];
    logic          move [SLOTS];
    logic          swap [SLOTS];

    psds_pkg::cell_ctl_t ctl;
    logic [PW-1:0]       new_pt;

    // Controller state.
    psds_pkg::state_t state_reg, state_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    psds_pkg::rsp_t   rsp_reg, rsp_next;

    logic accept;
    logic load_rsp;
    logic full;
    logic empty;
    logic sort_last;
    psds_pkg::op_t req_op;

    // Coordinates keep only their low COORD_BITS bits.
    logic [CB+15:0] ext_x, ext_y, ext_z;
    assign ext_x  = {CB'(0), req.coord_x};
    assign ext_y  = {CB'(0), req.coord_y};
    assign ext_z  = {CB'(0), req.coord_z};
    assign new_pt = {ext_x[CB-1:0], ext_y[CB-1:0], ext_z[CB-1:0]};

    // Read path: the addressed slot, reported empty when outside the table.
    logic           rd_hit;
    logic [IW-1:0]  rd_idx;
    logic           rd_present;
    logic [PW-1:0]  rd_pt;
    logic [CB+15:0] rd_sx, rd_sy, rd_sz;

    assign rd_hit     = (32'(req.slot_index) < SLOTS);
    assign rd_idx     = IW'(req.slot_index);
    assign rd_present = rd_hit && cell_v[rd_idx];
    assign rd_pt      = cell_pt[rd_idx];
    assign rd_sx      = {{16{rd_pt[PW-1]}}, rd_pt[PW-1:2*CB]};
    assign rd_sy      = {{16{rd_pt[2*CB-1]}}, rd_pt[2*CB-1:CB]};
    assign rd_sz      = {{16{rd_pt[CB-1]}}, rd_pt[CB-1:0]};

    // A new request is taken only between operations and when the response
    // register is free or being emptied in the same cycle.
    assign req_stall = (state_reg != psds_pkg::ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign req_op    = psds_pkg::op_t'(req.req_type);
    assign full      = (count_reg == CNT_W'(SLOTS));
    assign empty     = (count_reg == '0);
    assign sort_last = (phase_reg == PH_W'(SLOTS - 1));

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            localparam bit BOT = (gi == 0);
            localparam bit TOP = (gi == SLOTS - 1);
            localparam int LO  = BOT ? 0 : gi - 1;
            localparam int HI  = TOP ? 0 : gi + 1;

            psds_cell #(
                .CB        (CB),
                .DW        (DW),
                .IDX_ODD   (gi % 2 == 1),
                .IS_BOTTOM (BOT),
                .IS_TOP    (TOP)
            ) u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .ctl             (ctl),
                .new_pt          (new_pt),
                .below_v         (cell_v[LO]),
                .below_pt        (cell_pt[LO]),
                .below_d         (cell_d[LO]),
                // The top cell sees slot 0 above it, which gives the rotate wrap.
                .above_v         (cell_v[HI]),
                .above_pt        (cell_pt[HI]),
                .above_d         (cell_d[HI]),
                .free_below_in   (BOT ? 1'b0 : free_below[LO]),
                .free_below_out  (free_below[gi]),
                .valid_below_in  (BOT ? 1'b0 : valid_below[LO]),
                .valid_below_out (valid_below[gi]),
                .valid_above_in  (TOP ? 1'b0 : valid_above[HI]),
                .valid_above_out (valid_above[gi]),
                .hole_in         (TOP ? 1'b0 : hole[HI]),
                .hole_out        (hole[gi]),
                .move_in         (BOT ? 1'b0 : move[LO]),
                .move_out        (move[gi]),
                .swap_in         (BOT ? 1'b0 : swap[LO]),
                .swap_out        (swap[gi]),
                .v               (cell_v[gi]),
                .pt              (cell_pt[gi]),
                .d               (cell_d[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            psds_pkg::ST_IDLE:
            begin
                if (accept && req_op == psds_pkg::OP_SORT)
                    state_next = psds_pkg::ST_DIST;
                phase_next = '0;
            end
            psds_pkg::ST_DIST:
            begin
                state_next = psds_pkg::ST_SORT;
            end
            psds_pkg::ST_SORT:
            begin
                if (sort_last)
                    state_next = psds_pkg::ST_IDLE;
                phase_next = phase_reg + PH_W'(1);
            end
            default:
            begin
                state_next = psds_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: cell operation, count update and the response.
    always_comb
    begin
        ctl.op        = psds_pkg::CELL_HOLD;
        ctl.odd_phase = phase_reg[0];
        count_next    = count_reg;
        load_rsp      = 1'b0;
        rsp_next      = '0;
        rsp_next.status = psds_pkg::STATUS_DONE;
        unique case (state_reg)
            psds_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load_rsp = (req_op != psds_pkg::OP_SORT);
                    unique case (req_op)
                        psds_pkg::OP_ADD_TOP, psds_pkg::OP_ADD_BOT:
                        begin
                            if (full)
                                rsp_next.status = psds_pkg::STATUS_FULL;
                            else
                            begin
                                ctl.op = (req_op == psds_pkg::OP_ADD_TOP) ?
                                         psds_pkg::CELL_ADD_TOP : psds_pkg::CELL_ADD_BOT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        psds_pkg::OP_REM_TOP, psds_pkg::OP_REM_BOT:
                        begin
                            if (empty)
                                rsp_next.status = psds_pkg::STATUS_EMPTY;
                            else
                            begin
                                ctl.op = (req_op == psds_pkg::OP_REM_TOP) ?
                                         psds_pkg::CELL_REM_TOP : psds_pkg::CELL_REM_BOT;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        psds_pkg::OP_ROTATE:
                            ctl.op = psds_pkg::CELL_ROTATE;
                        psds_pkg::OP_CLEAR:
                        begin
                            ctl.op     = psds_pkg::CELL_CLEAR;
                            count_next = '0;
                        end
                        psds_pkg::OP_READ:
                        begin
                            rsp_next.slot_present = rd_present;
                            rsp_next.slot_x = rd_present ? rd_sx[15:0] : 16'sd0;
                            rsp_next.slot_y = rd_present ? rd_sy[15:0] : 16'sd0;
                            rsp_next.slot_z = rd_present ? rd_sz[15:0] : 16'sd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            psds_pkg::ST_DIST:
            begin
                ctl.op = psds_pkg::CELL_DIST;
            end
            psds_pkg::ST_SORT:
            begin
                // Empty slots rank above every present point, so each phase
                // both compacts and orders by distance while keeping ties stable.
                ctl.op   = psds_pkg::CELL_SWAP;
                load_rsp = sort_last;
            end
            default:
            begin
            end
        endcase
        rsp_next.point_count = 5'(count_next);
    end

    assign rsp_valid_next = load_rsp ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psds_pkg::ST_IDLE;
            phase_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the cell row against the controller's bookkeeping.
    logic [SLOTS-1:0] v_vec;
    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
            v_vec[k] = cell_v[k];
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("point count beyond table size");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == psds_pkg::ST_IDLE |-> 32'($countones(v_vec)) == 32'(count_reg))
        else $error("point count differs from occupied slots");

    a_sort_compact: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == psds_pkg::ST_SORT && sort_last |=>
        (v_vec & (v_vec + SLOTS'(1))) == '0)
        else $error("sort left a gap among present points");

endmodule

// File: hw/rtl/psds_cell.sv
// ============================================================================
// psds_cell: one slot of the point table
// Holds a present flag, a point and its squared distance. Talks to its lower
// and upper neighbors through ripple chains and content exchange.
// ============================================================================
module psds_cell #(
    parameter int CB        = 16,
    parameter int DW        = 32,
    parameter bit IDX_ODD   = 1'b0,
    parameter bit IS_BOTTOM = 1'b0,
    parameter bit IS_TOP    = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psds_pkg::cell_ctl_t ctl,
    input  logic [3*CB-1:0]     new_pt,
    // Neighbor contents.
    input  logic                below_v,
    input  logic [3*CB-1:0]     below_pt,
    input  logic [DW-1:0]       below_d,
    input  logic                above_v,
    input  logic [3*CB-1:0]     above_pt,
    input  logic [DW-1:0]       above_d,
    // Ripple chains.
    input  logic                free_below_in,
    output logic                free_below_out,
    input  logic                valid_below_in,
    output logic                valid_below_out,
    input  logic                valid_above_in,
    output logic                valid_above_out,
    input  logic                hole_in,
    output logic                hole_out,
    input  logic                move_in,
    output logic                move_out,
    input  logic                swap_in,
    output logic                swap_out,
    // Own contents.
    output logic                v,
    output logic [3*CB-1:0]     pt,
    output logic [DW-1:0]       d
);

    logic              v_reg, v_next;
    logic [3*CB-1:0]   pt_reg, pt_next;
    logic [DW-1:0]     d_reg, d_next;
    logic signed [CB-1:0]   px, py, pz;
    logic signed [2*CB-1:0] sx, sy, sz;
    logic              pair_act;

    assign px = pt_reg[3*CB-1:2*CB];
    assign py = pt_reg[2*CB-1:CB];
    assign pz = pt_reg[CB-1:0];
    assign sx = px * px;
    assign sy = py * py;
    assign sz = pz * pz;

    assign pair_act = (IDX_ODD == ctl.odd_phase);

    assign free_below_out  = free_below_in | ~v_reg;
    assign valid_below_out = valid_below_in | v_reg;
    assign valid_above_out = valid_above_in | v_reg;
    assign hole_out        = ~v_reg | hole_in;
    assign move_out        = v_reg & hole_in;
    assign swap_out        = !IS_TOP && (ctl.op == psds_pkg::CELL_SWAP) && pair_act &&
                             ((!v_reg && above_v) || (v_reg && above_v && d_reg > above_d));

    always_comb
    begin
        v_next  = v_reg;
        pt_next = pt_reg;
        d_next  = d_reg;
        unique case (ctl.op)
            psds_pkg::CELL_ADD_TOP:
            begin
                if (!v_reg && !free_below_in)
                begin
                    v_next  = 1'b1;
                    pt_next = new_pt;
                end
            end
            psds_pkg::CELL_REM_TOP:
            begin
                if (v_reg && !valid_above_in)
                    v_next = 1'b0;
            end
            psds_pkg::CELL_REM_BOT:
            begin
                if (v_reg && !valid_below_in)
                    v_next = 1'b0;
            end
            psds_pkg::CELL_ADD_BOT:
            begin
                if (IS_BOTTOM)
                begin
                    v_next  = 1'b1;
                    pt_next = new_pt;
                end
                else if (move_in)
                begin
                    v_next  = below_v;
                    pt_next = below_pt;
                end
                else if (move_out)
                    v_next = 1'b0;
            end
            psds_pkg::CELL_ROTATE:
            begin
                v_next  = above_v;
                pt_next = above_pt;
            end
            psds_pkg::CELL_CLEAR:
            begin
                v_next  = 1'b0;
                pt_next = '0;
            end
            psds_pkg::CELL_DIST:
            begin
                d_next = DW'(unsigned'(sx)) + DW'(unsigned'(sy)) + DW'(unsigned'(sz));
            end
            psds_pkg::CELL_SWAP:
            begin
                if (swap_out)
                begin
                    v_next  = above_v;
                    pt_next = above_pt;
                    d_next  = above_d;
                end
                else if (swap_in)
                begin
                    v_next  = below_v;
                    pt_next = below_pt;
                    d_next  = below_d;
                end
            end
            psds_pkg::CELL_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
        d_reg  <= d_next;
    end

    assign v  = v_reg;
    assign pt = pt_reg;
    assign d  = d_reg;

endmodule

// File: bench/point_slot_table_with_distance_sort_test.sv
// ============================================================================
// point_slot_table_with_distance_sort_test: checks the point slot table
// Feeds directed and random requests through a valid/stall driver, keeps a
// shadow table that computes each response, and compares every response
// field by field against the oldest prediction.
// ============================================================================
module point_slot_table_with_distance_sort_test;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    psds_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    psds_pkg::rsp_t rsp;

    point_slot_table_with_distance_sort uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table.
    logic signed [15:0] tbl_x [NSLOT];
    logic signed [15:0] tbl_y [NSLOT];
    logic signed [15:0] tbl_z [NSLOT];
    logic               tbl_on [NSLOT];
    int                 tbl_count;

    psds_pkg::req_t pending_reqs[$];
    psds_pkg::rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   stimulus_done = 0;
    bit   hold_rsp = 0;

    function automatic longint sq_dist(int i);
        longint x, y, z;
        x = tbl_x[i];
        y = tbl_y[i];
        z = tbl_z[i];
        return x * x + y * y + z * z;
    endfunction

    // Copies slot s to slot d, coordinates and present flag.
    function automatic void move_slot(int d, int s);
        tbl_x[d] = tbl_x[s];
        tbl_y[d] = tbl_y[s];
        tbl_z[d] = tbl_z[s];
        tbl_on[d] = tbl_on[s];
    endfunction

    function automatic void put_point(int i, psds_pkg::req_t r);
        tbl_x[i] = r.coord_x;
        tbl_y[i] = r.coord_y;
        tbl_z[i] = r.coord_z;
        tbl_on[i] = 1'b1;
    endfunction

    // Applies one request to the shadow table and returns the response.
    function automatic psds_pkg::rsp_t table_response(psds_pkg::req_t r);
        psds_pkg::rsp_t o;
        int n;
        logic signed [15:0] hx, hy, hz;
        logic hon;
        o = '0;
        case (r.req_type)
            psds_pkg::OP_ADD_TOP, psds_pkg::OP_ADD_BOT:
            begin
                if (tbl_count >= NSLOT)
                begin
                    o.status = psds_pkg::STATUS_FULL;
                end
                else if (r.req_type == psds_pkg::OP_ADD_TOP)
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!tbl_on[i])
                        begin
                            put_point(i, r);
                            break;
                        end
                    end
                    tbl_count++;
                end
                else
                begin
                    // Each present slot below a gap shifts up, top-down.
                    for (int i = NSLOT - 2; i >= 0; i--)
                    begin
                        if (tbl_on[i] && !tbl_on[i + 1])
                        begin
                            move_slot(i + 1, i);
                            tbl_on[i] = 1'b0;
                        end
                    end
                    put_point(0, r);
                    tbl_count++;
                end
            end
            psds_pkg::OP_REM_TOP:
            begin
                if (tbl_count == 0)
                begin
                    o.status = psds_pkg::STATUS_EMPTY;
                end
                else
                begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                    begin
                        if (tbl_on[i])
                        begin
                            tbl_on[i] = 1'b0;
                            tbl_count--;
                            break;
                        end
                    end
                end
            end
            psds_pkg::OP_REM_BOT:
            begin
                if (tbl_count == 0)
                begin
                    o.status = psds_pkg::STATUS_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (tbl_on[i])
                        begin
                            tbl_on[i] = 1'b0;
                            tbl_count--;
                            break;
                        end
                    end
                end
            end
            psds_pkg::OP_ROTATE:
            begin
                hx = tbl_x[0];
                hy = tbl_y[0];
                hz = tbl_z[0];
                hon = tbl_on[0];
                for (int i = 1; i < NSLOT; i++)
                begin
                    move_slot(i - 1, i);
                end
                tbl_x[NSLOT - 1] = hx;
                tbl_y[NSLOT - 1] = hy;
                tbl_z[NSLOT - 1] = hz;
                tbl_on[NSLOT - 1] = hon;
            end
            psds_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    tbl_x[i] = '0;
                    tbl_y[i] = '0;
                    tbl_z[i] = '0;
                    tbl_on[i] = 1'b0;
                end
                tbl_count = 0;
            end
            psds_pkg::OP_SORT:
            begin
                n = 0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (tbl_on[i])
                    begin
                        move_slot(n, i);
                        n++;
                    end
                end
                for (int i = n; i < NSLOT; i++)
                begin
                    tbl_on[i] = 1'b0;
                end
                // Bubble sort keeps equal distances in order.
                for (int p = 0; p + 1 < n; p++)
                begin
                    for (int j = 0; j + 1 < n; j++)
                    begin
                        if (sq_dist(j) > sq_dist(j + 1))
                        begin
                            hx = tbl_x[j];
                            hy = tbl_y[j];
                            hz = tbl_z[j];
                            move_slot(j, j + 1);
                            tbl_x[j + 1] = hx;
                            tbl_y[j + 1] = hy;
                            tbl_z[j + 1] = hz;
                            tbl_on[j + 1] = 1'b1;
                        end
                    end
                end
            end
            psds_pkg::OP_READ:
            begin
                if (tbl_on[r.slot_index])
                begin
                    o.slot_present = 1'b1;
                    o.slot_x = tbl_x[r.slot_index];
                    o.slot_y = tbl_y[r.slot_index];
                    o.slot_z = tbl_z[r.slot_index];
                end
            end
            default:
            begin
            end
        endcase
        o.point_count = 5'(tbl_count);
        return o;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(0);
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic psds_pkg::req_t make_req(logic [3:0] kind);
        psds_pkg::req_t r;
        r.req_type = kind;
        r.coord_x = rand_coord();
        r.coord_y = rand_coord();
        r.coord_z = rand_coord();
        r.slot_index = 4'($urandom);
        return r;
    endfunction

    // Mostly adds and reads so the table often fills; sorts are less common
    // because each one keeps the block busy through its exchange phases.
    function automatic logic [3:0] pick_kind();
        int w;
        w = $urandom_range(0, 99);
        if (w < 22) return psds_pkg::OP_ADD_TOP;
        if (w < 38) return psds_pkg::OP_ADD_BOT;
        if (w < 48) return psds_pkg::OP_REM_TOP;
        if (w < 58) return psds_pkg::OP_REM_BOT;
        if (w < 62) return psds_pkg::OP_COUNT;
        if (w < 68) return psds_pkg::OP_ROTATE;
        if (w < 70) return psds_pkg::OP_CLEAR;
        if (w < 78) return psds_pkg::OP_SORT;
        if (w < 97) return psds_pkg::OP_READ;
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic int gap_len();
        int w;
        w = $urandom_range(0, 99);
        if (w < 55) return 0;
        if (w < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        psds_pkg::req_t r;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_z[i] = '0;
            tbl_on[i] = 1'b0;
        end
        tbl_count = 0;

        // Directed part: removes on an empty table, every code, the
        // coordinate extremes, reads of slots 0, 1, 2 and 15, and the
        // unused codes 9 and 15.
        pending_reqs.push_back(make_req(psds_pkg::OP_REM_TOP));
        pending_reqs.push_back(make_req(psds_pkg::OP_REM_BOT));
        r = make_req(psds_pkg::OP_ADD_TOP);
        r.coord_x = 16'h8000;
        r.coord_y = 16'h8000;
        r.coord_z = 16'h8000;
        pending_reqs.push_back(r);
        r.coord_x = 16'h7fff;
        r.coord_y = 16'h0000;
        r.coord_z = 16'hffff;
        pending_reqs.push_back(r);
        r.req_type = psds_pkg::OP_ADD_BOT;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(psds_pkg::OP_SORT));
        pending_reqs.push_back(make_req(psds_pkg::OP_ROTATE));
        pending_reqs.push_back(make_req(psds_pkg::OP_COUNT));
        for (int i = 0; i < 4; i++)
        begin
            r = make_req(psds_pkg::OP_READ);
            r.slot_index = (i == 3) ? 4'hf : 4'(i);
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_req(psds_pkg::OP_REM_BOT));
        pending_reqs.push_back(make_req(psds_pkg::OP_REM_TOP));
        for (int i = 0; i < 6; i++)
        begin
            pending_reqs.push_back(make_req(i % 2 ? psds_pkg::OP_ADD_BOT :
                psds_pkg::OP_ADD_TOP));
        end
        pending_reqs.push_back(make_req(4'd9));
        pending_reqs.push_back(make_req(4'd15));
        pending_reqs.push_back(make_req(psds_pkg::OP_CLEAR));

        // Random part: bursts of adds fill the table so full status and the
        // complete sort are reached; the rest mixes all codes.
        while (pending_reqs.size() < 1000)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(12, 20))
                    pending_reqs.push_back(make_req($urandom_range(0, 1) ?
                        psds_pkg::OP_ADD_TOP : psds_pkg::OP_ADD_BOT));
                pending_reqs.push_back(make_req(psds_pkg::OP_SORT));
                for (int i = 0; i < NSLOT; i++)
                begin
                    r = make_req(psds_pkg::OP_READ);
                    r.slot_index = 4'(i);
                    pending_reqs.push_back(r);
                end
            end
            else
            begin
                pending_reqs.push_back(make_req(pick_kind()));
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Acceptance flag latched at the rising edge for the driver to use.
    bit req_taken = 0;
    always @(posedge clk)
    begin
        req_taken <= req_valid && !req_stall;
    end

    // Driver: offers the head of the queue and keeps it steady while stalled.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    send_gap <= gap_len();
                end
                else
                begin
                    req_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Prediction at the rising edge where a request transaction completes.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsps.push_back(table_response(req));
        end
    end

    // Receiver stall: random gaps, plus one long hold while requests keep
    // coming so that the block backs up and stalls its input.
    int hold_left = 0;
    int stall_left = 0;
    int rsp_seen = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!hold_rsp && rsp_seen == 200)
        begin
            hold_rsp <= 1'b1;
            hold_left <= 300;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: compares each response transaction with the oldest prediction.
    always @(posedge clk)
    begin
        psds_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected response %p", rsp);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status || rsp.point_count !== want.point_count
                    || rsp.slot_present !== want.slot_present
                    || rsp.slot_x !== want.slot_x || rsp.slot_y !== want.slot_y
                    || rsp.slot_z !== want.slot_z)
                begin
                    if (mismatches < 10)
                        $display("response mismatch: expected %p got %p", want, rsp);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_slot_table_with_distance_sort_test failed");
            $finish;
        end
    end

    // End of run: all requests sent, all responses seen, then a short drain
    // in which a stray response would still be caught.
    initial
    begin
        wait (stimulus_done && expected_rsps.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("point_slot_table_with_distance_sort_test passed");
        else
            $display("point_slot_table_with_distance_sort_test failed");
        $finish;
    end

endmodule
